@@ hdl/nested_section_profiler_unit_assert.svh @@
// assertion macros for the section profiler
`ifndef NESTED_SECTION_PROFILER_UNIT_ASSERT_SVH
`define NESTED_SECTION_PROFILER_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define NSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define NSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/nsp_pkg.sv @@
// -----------------------------------------------------------------------------
// nsp_pkg
// shared types and codes of the nested section profiler
// -----------------------------------------------------------------------------
`default_nettype none
package nsp_pkg;

  // table and stack sizes, fixed by the port widths
  localparam int MARKERS     = 16;
  localparam int STACK_DEPTH = 16;
  localparam int TIME_BITS   = 32;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_END       = 3'd1,
    OP_RST_MARK  = 3'd2,
    OP_RST_ALL   = 3'd3,
    OP_RST_SESS  = 3'd4,
    OP_QUERY     = 3'd5,
    OP_SPARE6    = 3'd6,
    OP_SPARE7    = 3'd7
  } nsp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CREDIT,
    ST_CLEAR,
    ST_REPORT
  } nsp_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic update;     // apply start/end/reset marker to the selected entry
    logic credit;     // add duration to the parent's child accumulator
    logic clear;      // apply reset-all or session reset to one entry
    logic report;     // drive the result strobe
  } nsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        need_credit;
    logic        need_sweep;
    logic        sweep_last;
  } nsp_status_t;

endpackage
`default_nettype wire

@@ hdl/nsp_ctrl.sv @@
// -----------------------------------------------------------------------------
// nsp_ctrl
// sequencer for one profiler operation
// -----------------------------------------------------------------------------
`default_nettype none
module nsp_ctrl
  import nsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire nsp_status_t status_i,
  output nsp_cmd_t         cmd_o,
  output logic             busy_o
);

  nsp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (status_i.need_sweep) state_d = ST_CLEAR;
        else if (status_i.need_credit) state_d = ST_CREDIT;
        else state_d = ST_REPORT;
      end
      ST_CREDIT: state_d = ST_REPORT;
      ST_CLEAR:  if (status_i.sweep_last) state_d = ST_REPORT;
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_CREDIT: cmd_o.credit = 1'b1;
      ST_CLEAR:  cmd_o.clear  = 1'b1;
      ST_REPORT: cmd_o.report = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/nsp_datapath.sv @@
// -----------------------------------------------------------------------------
// nsp_datapath
// per-marker statistics tables, call stack and result registers
// -----------------------------------------------------------------------------
`default_nettype none
module nsp_datapath
  import nsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire nsp_cmd_t    cmd_i,
  output nsp_status_t      status_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [3:0]  marker_i,
  input  wire logic [31:0] timestamp_i,
  output logic             done_o,
  output logic [31:0]      last_time_o,
  output logic [47:0]      total_time_o,
  output logic [31:0]      shortest_time_o,
  output logic [31:0]      longest_time_o,
  output logic [31:0]      calls_done_o,
  output logic [31:0]      self_time_o,
  output logic [47:0]      children_total_o,
  output logic [16:0]      parents_seen_o,
  output logic             in_session_o,
  output logic             multi_parent_o,
  output logic [4:0]       nest_level_o
);

  localparam int MW = (MARKERS > 1) ? $clog2(MARKERS) : 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;

  // entry tables, cleared at reset (16 entries, indices 0 to 15)
  logic [TB-1:0]  start_q  [MARKERS];
  logic [TB-1:0]  last_q   [MARKERS];
  logic [47:0]    total_q  [MARKERS];
  logic [TB-1:0]  min_q    [MARKERS];
  logic [TB-1:0]  max_q    [MARKERS];
  logic [TB-1:0]  crun_q   [MARKERS];
  logic [TB-1:0]  clast_q  [MARKERS];
  logic [47:0]    csum_q   [MARKERS];
  logic [31:0]    tally_q  [MARKERS];
  logic [MARKERS:0] pbits_q [MARKERS];
  logic [MARKERS-1:0] sess_q;

  logic [3:0]     stack_q [STACK_DEPTH];
  logic [LW-1:0]  level_q;

  logic [2:0]     op_q;
  logic [3:0]     mark_q;
  logic [TB-1:0]  now_q;
  logic [TB-1:0]  dur_q;
  logic [MW-1:0]  sweep_q;

  logic           valid_m;
  logic [MW-1:0]  mi;
  logic [TB-1:0]  dur;
  logic [3:0]     top;
  logic [3:0]     top_after;
  logic [MARKERS:0] pbit;

  assign valid_m = ({1'b0, mark_q} < 5'(MARKERS));
  assign mi      = mark_q[MW-1:0];
  assign dur     = now_q - start_q[mi];
  assign top       = (level_q != '0) ? stack_q[SW'(level_q - 1'b1)] : 4'd0;
  assign top_after = (level_q > LW'(1)) ? stack_q[SW'(level_q - LW'(2))] : 4'd0;

  always_comb begin
    pbit = '0;
    if (level_q != '0 && {1'b0, top} < 5'(MARKERS)) pbit[top[MW-1:0]] = 1'b1;
    else pbit[MARKERS] = 1'b1;
  end

  always_comb begin
    status_o.need_sweep  = (op_q == OP_RST_ALL) || (op_q == OP_RST_SESS);
    status_o.need_credit = (op_q == OP_END) && valid_m && (level_q > LW'(1))
                           && ({1'b0, top_after} < 5'(MARKERS));
    status_o.sweep_last  = (sweep_q == MW'(MARKERS - 1));
  end

  // stack storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && op_q == OP_START && valid_m && level_q < LW'(STACK_DEPTH))
      stack_q[SW'(level_q)] <= mark_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      sweep_q <= '0;
      sess_q  <= '0;
      op_q    <= OP_QUERY;
      mark_q  <= '0;
      now_q   <= '0;
      dur_q   <= '0;
      for (int i = 0; i < MARKERS; i++) begin
        start_q[i] <= '0; last_q[i] <= '0; total_q[i] <= '0; min_q[i] <= '0;
        max_q[i] <= '0; crun_q[i] <= '0; clast_q[i] <= '0; csum_q[i] <= '0;
        tally_q[i] <= '0; pbits_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        op_q    <= operation_i;
        mark_q  <= marker_i;
        now_q   <= timestamp_i[TB-1:0];
        sweep_q <= '0;
      end
      if (cmd_i.update && valid_m) begin
        unique case (op_q)
          OP_START: begin
            pbits_q[mi] <= pbits_q[mi] | pbit;
            crun_q[mi]  <= '0;
            sess_q[mi]  <= 1'b1;
            start_q[mi] <= now_q;
            if (level_q < LW'(STACK_DEPTH)) level_q <= level_q + 1'b1;
          end
          OP_END: begin
            dur_q       <= dur;
            last_q[mi]  <= dur;
            total_q[mi] <= total_q[mi] + 48'(dur);
            if (tally_q[mi] == '0 || dur < min_q[mi]) min_q[mi] <= dur;
            if (dur > max_q[mi]) max_q[mi] <= dur;
            tally_q[mi] <= tally_q[mi] + 32'd1;
            clast_q[mi] <= crun_q[mi];
            csum_q[mi]  <= csum_q[mi] + 48'(crun_q[mi]);
            if (level_q != '0) level_q <= level_q - 1'b1;
          end
          OP_RST_MARK: begin
            start_q[mi] <= '0; last_q[mi] <= '0; total_q[mi] <= '0;
            min_q[mi] <= '0; max_q[mi] <= '0; crun_q[mi] <= '0;
            clast_q[mi] <= '0; csum_q[mi] <= '0; tally_q[mi] <= '0;
            pbits_q[mi] <= '0; sess_q[mi] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.credit)
        crun_q[top[MW-1:0]] <= crun_q[top[MW-1:0]] + dur_q;
      if (cmd_i.clear) begin
        level_q <= '0;
        sweep_q <= sweep_q + 1'b1;
        crun_q[sweep_q]  <= '0;
        pbits_q[sweep_q] <= '0;
        sess_q[sweep_q]  <= 1'b0;
        if (op_q == OP_RST_ALL) begin
          start_q[sweep_q] <= '0; last_q[sweep_q] <= '0; total_q[sweep_q] <= '0;
          min_q[sweep_q] <= '0; max_q[sweep_q] <= '0; clast_q[sweep_q] <= '0;
          csum_q[sweep_q] <= '0; tally_q[sweep_q] <= '0;
        end
      end
    end
  end

  // result read from the entry after the operation
  always_comb begin
    done_o           = cmd_i.report;
    last_time_o      = '0;
    total_time_o     = '0;
    shortest_time_o  = '0;
    longest_time_o   = '0;
    calls_done_o     = '0;
    self_time_o      = '0;
    children_total_o = '0;
    parents_seen_o   = '0;
    in_session_o     = 1'b0;
    multi_parent_o   = 1'b0;
    nest_level_o     = 5'(level_q);
    if (valid_m) begin
      last_time_o      = 32'(last_q[mi]);
      total_time_o     = total_q[mi];
      shortest_time_o  = 32'(min_q[mi]);
      longest_time_o   = 32'(max_q[mi]);
      calls_done_o     = tally_q[mi];
      self_time_o      = (clast_q[mi] <= last_q[mi]) ? 32'(last_q[mi] - clast_q[mi]) : '0;
      children_total_o = csum_q[mi];
      parents_seen_o   = 17'(pbits_q[mi]);
      in_session_o     = sess_q[mi];
      multi_parent_o   = (pbits_q[mi] & (pbits_q[mi] - 1'b1)) != '0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/nested_section_profiler_unit.sv @@
// -----------------------------------------------------------------------------
// nested_section_profiler_unit
// hardware profiler for nested code sections
// -----------------------------------------------------------------------------
// usage: drive operation_i, marker_i and timestamp_i with start_i high; the
// transfer is taken at the edge where start_i is high and busy_o low.
// one result follows, shown for a single cycle with done_o high; the
// receiver cannot stall and must take it in that cycle.
// sequence: the item is captured at the accepting edge, applied in the
// update state, then shown in the report state; an end with a parent
// to credit adds the credit state (one extra read-modify-write of the
// parent's entry); reset all and session reset add the clear state, one
// table entry swept per cycle. throughput: busy_o stays high through
// the result cycle; the next transfer is taken the cycle after at best.
// reset: all statistics, flags and the stack depth clear at once; the
// stack contents are left as they are and only read below the depth.
// -----------------------------------------------------------------------------
`default_nettype none
module nested_section_profiler_unit
  import nsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [3:0]  marker_i,
  input  wire logic [31:0] timestamp_i,
  output logic             done_o,
  output logic [31:0]      last_time_o,
  output logic [47:0]      total_time_o,
  output logic [31:0]      shortest_time_o,
  output logic [31:0]      longest_time_o,
  output logic [31:0]      calls_done_o,
  output logic [31:0]      self_time_o,
  output logic [47:0]      children_total_o,
  output logic [16:0]      parents_seen_o,
  output logic             in_session_o,
  output logic             multi_parent_o,
  output logic [4:0]       nest_level_o
);

  nsp_cmd_t    cmd;
  nsp_status_t status;

  // sequencer
  nsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // tables and stack
  nsp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (operation_i),
    .marker_i         (marker_i),
    .timestamp_i      (timestamp_i),
    .done_o           (done_o),
    .last_time_o      (last_time_o),
    .total_time_o     (total_time_o),
    .shortest_time_o  (shortest_time_o),
    .longest_time_o   (longest_time_o),
    .calls_done_o     (calls_done_o),
    .self_time_o      (self_time_o),
    .children_total_o (children_total_o),
    .parents_seen_o   (parents_seen_o),
    .in_session_o     (in_session_o),
    .multi_parent_o   (multi_parent_o),
    .nest_level_o     (nest_level_o)
  );

endmodule
`default_nettype wire

@@ hdl/nsp_checker.sv @@
// -----------------------------------------------------------------------------
// nsp_checker
// port-level checks on the profiler
// -----------------------------------------------------------------------------
`default_nettype none
`include "nested_section_profiler_unit_assert.svh"
module nsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        multi_parent_o,
  input wire logic [16:0] parents_seen_o,
  input wire logic [4:0]  nest_level_o
);

  `NSP_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, start_i && !busy_o, busy_o, "not busy after transfer")
  `NSP_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o, "result outside busy")
  `NSP_ASSERT_NEXT(a_free_after_done, clk_i, rst_ni, done_o, !busy_o && !done_o, "result not single")
  `NSP_ASSERT_IMP(a_multi, clk_i, rst_ni, done_o, multi_parent_o == ($countones(parents_seen_o) > 1), "multi parent flag wrong")
  `NSP_ASSERT_IMP(a_level, clk_i, rst_ni, done_o, nest_level_o <= 5'd16, "stack depth out of range")

endmodule

bind nested_section_profiler_unit nsp_checker u_nsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .multi_parent_o (multi_parent_o),
  .parents_seen_o (parents_seen_o),
  .nest_level_o   (nest_level_o)
);
`default_nettype wire
